>>> src/mcpr_pkg.sv
`timescale 1ns / 1ps
// mcpr_pkg: store depth, field widths and command codes of the
// multi-channel parameter ramp. No dependencies.
package mcpr_pkg;

	localparam int N_PARAMS = 64;
	localparam int ADDR_W   = (N_PARAMS > 1) ? $clog2(N_PARAMS) : 1;

	localparam int CMD_W    = 2;
	localparam int INDEX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 16;
	localparam int RECIP_W  = 25;

	localparam logic [RECIP_W-1:0] RECIP_ONE = 25'h100_0000;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET_CURRENT = 2'd0,
		CMD_SET_TARGET  = 2'd1,
		CMD_ADVANCE     = 2'd2,
		CMD_READ        = 2'd3
	} cmd_t;

endpackage

>>> src/multi_channel_parameter_ramp.sv
`timescale 1ns / 1ps
// multi_channel_parameter_ramp: current value and increment stores with a
// three-stage read-multiply-writeback pipeline. Depends on mcpr_pkg.
//
// set_current: written at the accept edge, busy stays low.
// set_target and read: busy until stage 3 ends; the read strobe rises as busy drops.
// advance: the walk reads one entry per cycle, busy until the last entry drains.
// reset: a clearing pass writes zero to both stores, one entry per cycle,
// busy until the last entry is written; config beats are taken at any time.
// results leave on a one-cycle strobe, the receiver cannot stall.
module multi_channel_parameter_ramp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [mcpr_pkg::CMD_W-1:0]          cmd,
	input  logic [mcpr_pkg::INDEX_W-1:0]        index,
	input  logic signed [mcpr_pkg::VALUE_W-1:0] value,
	input  logic [mcpr_pkg::COUNT_W-1:0]        count,
	output logic                                read_valid,
	output logic signed [mcpr_pkg::VALUE_W-1:0] read_value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mcpr_pkg::RECIP_W-1:0]        cfg_data
);
	import mcpr_pkg::*;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(N_PARAMS - 1);

	state_t                state_q;
	logic [ADDR_W-1:0]     walk_q;
	logic [RECIP_W-1:0]    recip_q;
	cmd_t                  cmd_q;
	logic                  ok_q;
	logic [ADDR_W-1:0]     idx_q;
	logic signed [31:0]    value_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  read_valid_q;
	logic signed [31:0]    read_value_q;

	logic signed [31:0]    cur_mem [N_PARAMS];
	logic signed [31:0]    inc_mem [N_PARAMS];

	logic                  v_s1, v_s2, v_s3;
	logic                  last_s1, last_s2, last_s3;
	logic [ADDR_W-1:0]     addr_s1, addr_s2, addr_s3;
	logic signed [31:0]    cur_rd_s1, inc_rd_s1;
	logic signed [31:0]    cur_s2, cur_s3;
	logic signed [32:0]    opa_s2;
	logic signed [25:0]    opb_s2;
	logic signed [58:0]    prod_s3;

	logic                  accept;
	logic                  ok_in;
	logic                  issue;
	logic                  issue_last;
	logic [ADDR_W-1:0]     rd_addr;
	logic signed [32:0]    opa_d;
	logic signed [25:0]    opb_d;
	logic signed [58:0]    mul_d;
	logic signed [58:0]    pre_s3;
	logic                  fits_s3;
	logic signed [31:0]    res_s3;

	logic                  cur_we, inc_we;
	logic [ADDR_W-1:0]     cur_wa, inc_wa;
	logic signed [31:0]    cur_wd, inc_wd;

	assign busy       = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;
	assign read_valid = read_valid_q;
	assign read_value = read_value_q;

	assign accept     = start && !busy;
	assign ok_in      = (32'(index) < 32'(N_PARAMS));
	assign issue      = (state_q == ST_ISSUE);
	assign issue_last = (cmd_q != CMD_ADVANCE) || (walk_q == LAST_ADDR);
	assign rd_addr    = (cmd_q == CMD_ADVANCE) ? walk_q : idx_q;

	// reciprocal register, values above one clamp to one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recip_q <= RECIP_ONE;
		end else if (cfg_valid && cfg_ready) begin
			recip_q <= (cfg_data > RECIP_ONE) ? RECIP_ONE : cfg_data;
		end
	end

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			walk_q       <= '0;
			cmd_q        <= CMD_SET_CURRENT;
			ok_q         <= 1'b0;
			idx_q        <= '0;
			value_q      <= '0;
			count_q      <= '0;
			read_valid_q <= 1'b0;
			read_value_q <= '0;
		end else begin
			read_valid_q <= 1'b0;
			if (v_s3 && cmd_q == CMD_READ) begin
				read_valid_q <= 1'b1;
				read_value_q <= ok_q ? res_s3 : '0;
			end
			case (state_q)
				ST_CLEAR: begin
					walk_q <= walk_q + ADDR_W'(1);
					if (walk_q == LAST_ADDR) begin
						walk_q  <= '0;
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cmd_q   <= cmd_t'(cmd);
						ok_q    <= ok_in;
						idx_q   <= ADDR_W'(index);
						value_q <= value;
						count_q <= count;
						walk_q  <= '0;
						if (cmd_t'(cmd) != CMD_SET_CURRENT) begin
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					walk_q <= walk_q + ADDR_W'(1);
					if (issue_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (v_s3 && last_s3) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// memory write port selection, one writer per state
	always_comb begin
		cur_we = 1'b0;
		cur_wa = addr_s3;
		cur_wd = res_s3;
		inc_we = 1'b0;
		inc_wa = addr_s3;
		inc_wd = res_s3;
		case (state_q)
			ST_CLEAR: begin
				cur_we = 1'b1;
				cur_wa = walk_q;
				cur_wd = '0;
				inc_we = 1'b1;
				inc_wa = walk_q;
				inc_wd = '0;
			end
			ST_IDLE: begin
				if (accept && cmd_t'(cmd) == CMD_SET_CURRENT && ok_in) begin
					cur_we = 1'b1;
					cur_wa = ADDR_W'(index);
					cur_wd = value;
					inc_we = 1'b1;
					inc_wa = ADDR_W'(index);
					inc_wd = '0;
				end
			end
			default: begin
				cur_we = v_s3 && (cmd_q == CMD_ADVANCE);
				inc_we = v_s3 && ok_q && (cmd_q == CMD_SET_TARGET);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cur_we) begin
			cur_mem[cur_wa] <= cur_wd;
		end
		cur_rd_s1 <= cur_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (inc_we) begin
			inc_mem[inc_wa] <= inc_wd;
		end
		inc_rd_s1 <= inc_mem[rd_addr];
	end

	// stage 1: pick multiplier operands
	always_comb begin
		if (cmd_q == CMD_SET_TARGET) begin
			opa_d = {value_q[31], value_q} - {cur_rd_s1[31], cur_rd_s1};
			opb_d = {1'b0, recip_q};
		end else begin
			opa_d = {inc_rd_s1[31], inc_rd_s1};
			opb_d = {10'd0, count_q};
		end
	end

	assign mul_d = opa_s2 * opb_s2;

	// stage 3: shift or accumulate, then saturate
	always_comb begin
		if (cmd_q == CMD_SET_TARGET) begin
			pre_s3 = prod_s3 >>> 24;
		end else begin
			pre_s3 = {{27{cur_s3[31]}}, cur_s3} + prod_s3;
		end
		fits_s3 = (&pre_s3[58:31]) || !(|pre_s3[58:31]);
		if (fits_s3) begin
			res_s3 = pre_s3[31:0];
		end else if (pre_s3[58]) begin
			res_s3 = 32'sh8000_0000;
		end else begin
			res_s3 = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		last_s1 <= issue_last;
		addr_s1 <= rd_addr;
		last_s2 <= last_s1;
		addr_s2 <= addr_s1;
		cur_s2  <= cur_rd_s1;
		opa_s2  <= opa_d;
		opb_s2  <= opb_d;
		last_s3 <= last_s2;
		addr_s3 <= addr_s2;
		cur_s3  <= cur_s2;
		prod_s3 <= mul_d;
	end

	// a result beat only ever comes from a read
	assert property (@(posedge clk) disable iff (!arst_n)
		read_valid_q |-> (cmd_q == CMD_READ))
		else $error("result beat outside a read command");

	// idle means the pipeline has drained and all pipeline writes are done
	assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !(v_s1 || v_s2 || v_s3))
		else $error("pipeline busy while idle");

	// a single-entry command never has two entries in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_q != CMD_ADVANCE) |-> ($countones({v_s1, v_s2, v_s3}) <= 1))
		else $error("overlapping accesses on a single-entry command");

	// anything but set_current occupies the block after accept
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_t'(cmd) != CMD_SET_CURRENT) |=> busy)
		else $error("command accepted without going busy");

	// no clearing-pass write overlaps pipeline traffic
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !(v_s1 || v_s2 || v_s3 || read_valid_q))
		else $error("pipeline active during clearing pass");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for multi_channel_parameter_ramp, a directed table
// then random ramp sequences, with read beats checked against table values or a
// ramp predictor. Depends on mcpr_pkg and the multi_channel_parameter_ramp rtl.
module tb_top;
	import mcpr_pkg::*;

	typedef struct packed {
		cmd_t                op;
		logic [INDEX_W-1:0]  idx;
		logic [VALUE_W-1:0]  val;
		logic [COUNT_W-1:0]  cnt;
		logic                chk;
		logic [VALUE_W-1:0]  want;
	} stim_row_t;

	localparam int DIR_ROWS = 25;

	logic                       clk;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	cmd_t                       cmd;
	logic [INDEX_W-1:0]         index;
	logic signed [VALUE_W-1:0]  value;
	logic [COUNT_W-1:0]         count;
	logic                       read_valid;
	logic signed [VALUE_W-1:0]  read_value;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [RECIP_W-1:0]         cfg_data;

	// predictor state
	logic signed [VALUE_W-1:0]  level_mem [N_PARAMS];
	logic signed [VALUE_W-1:0]  slope_mem [N_PARAMS];
	int unsigned                recip_q24;

	logic signed [VALUE_W-1:0]  lookahead_q [$];
	logic signed [VALUE_W-1:0]  want_front;
	stim_row_t                  dir_tbl [DIR_ROWS];

	int errors;
	int items_sent;
	int reads_sent;
	int advances_sent;
	int reads_seen;
	int cfg_writes;
	int burst_left;
	bit steady;

	multi_channel_parameter_ramp dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.index      (index),
		.value      (value),
		.count      (count),
		.read_valid (read_valid),
		.read_value (read_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("multi_channel_parameter_ramp test failed");
		$finish;
	end

	function automatic logic signed [VALUE_W-1:0] clip32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	task automatic apply_ramp_cmd(input stim_row_t r, output bit has_read,
			output logic signed [VALUE_W-1:0] rd);
		longint acc;
		bit     ok;
		has_read = 1'b0;
		rd = '0;
		ok = (r.idx < N_PARAMS);
		case (r.op)
			CMD_SET_CURRENT: begin
				if (ok) begin
					level_mem[r.idx] = r.val;
					slope_mem[r.idx] = '0;
				end
			end
			CMD_SET_TARGET: begin
				if (ok) begin
					acc = (longint'($signed(r.val)) - longint'(level_mem[r.idx])) *
						longint'(recip_q24);
					// arithmetic shift floors toward minus infinity
					slope_mem[r.idx] = clip32(acc >>> 24);
				end
			end
			CMD_ADVANCE: begin
				for (int i = 0; i < N_PARAMS; i++)
					level_mem[i] = clip32(longint'(level_mem[i]) +
						longint'(slope_mem[i]) * longint'(r.cnt));
			end
			default: begin
				has_read = 1'b1;
				if (ok)
					rd = clip32(longint'(level_mem[r.idx]) +
						longint'(slope_mem[r.idx]) * longint'(r.cnt));
			end
		endcase
	endtask

	task automatic send_item(input stim_row_t r);
		bit                        got;
		logic signed [VALUE_W-1:0] rd;
		cmd   <= r.op;
		index <= r.idx;
		value <= r.val;
		count <= r.cnt;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		apply_ramp_cmd(r, got, rd);
		if (got) begin
			lookahead_q.push_back(r.chk ? $signed(r.want) : rd);
			reads_sent++;
		end
		if (r.op == CMD_ADVANCE)
			advances_sent++;
		items_sent++;
	endtask

	// sender bursts with random gaps, some long enough to outlast an advance walk
	task automatic pace();
		int gap;
		if (steady)
			return;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 15);
		gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 6);
		start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	task automatic send_paced(input stim_row_t r);
		send_item(r);
		pace();
	endtask

	// no beat in flight, then room for an advance walk that is still running
	task automatic settle();
		start <= 1'b0;
		while (lookahead_q.size() != 0)
			@(posedge clk);
		repeat (N_PARAMS + 8) @(posedge clk);
	endtask

	task automatic set_recip(input logic [RECIP_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		recip_q24 = 32'((v > RECIP_ONE) ? RECIP_ONE : v);
		cfg_writes++;
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int k;
		case ($urandom_range(0, 5))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: begin
				k = $urandom_range(0, 40);
				k = k - 20;
				return k * 65536;
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [COUNT_W-1:0] pick_steps(input bit wide);
		if (wide || $urandom_range(0, 7) == 0)
			return COUNT_W'($urandom);
		return COUNT_W'($urandom_range(0, 4));
	endfunction

	function automatic logic [INDEX_W-1:0] pick_index();
		if ($urandom_range(0, 3) == 0)
			return INDEX_W'($urandom_range(0, N_PARAMS - 1));
		return INDEX_W'($urandom_range(0, 3));
	endfunction

	task automatic run_phase(input int n_items);
		int                 base;
		logic [INDEX_W-1:0] ch;
		stim_row_t          r;
		base = items_sent;
		while (items_sent - base < n_items) begin
			if ($urandom_range(0, 9) < 7) begin
				// load, aim, then step and look ahead on the same entry
				ch = pick_index();
				send_paced('{CMD_SET_CURRENT, ch, pick_value(), 16'($urandom), 1'b0, 32'd0});
				send_paced('{CMD_SET_TARGET, ch, pick_value(), 16'($urandom), 1'b0, 32'd0});
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 2) == 0)
						r = '{CMD_ADVANCE, 6'($urandom), 32'($urandom), pick_steps(1'b0),
							1'b0, 32'd0};
					else
						r = '{CMD_READ, ch, 32'($urandom),
							pick_steps(1'($urandom_range(0, 1))), 1'b0, 32'd0};
					send_paced(r);
				end
			end else begin
				r = '{cmd_t'($urandom_range(0, 3)), 6'($urandom), 32'($urandom),
					16'($urandom), 1'b0, 32'd0};
				if (r.op == CMD_ADVANCE && $urandom_range(0, 1) == 0)
					r.cnt = pick_steps(1'b0);
				send_paced(r);
			end
		end
	endtask

	always @(posedge clk) begin
		if (read_valid === 1'b1) begin
			reads_seen++;
			if (lookahead_q.size() == 0) begin
				errors++;
				$display("%0t: read beat with none expected, actual %h", $time, read_value);
			end else begin
				want_front = lookahead_q.pop_front();
				if (read_value !== want_front) begin
					errors++;
					$display("%0t: read_value mismatch, expected %h actual %h",
						$time, want_front, read_value);
				end
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		cmd       <= CMD_SET_CURRENT;
		index     <= '0;
		value     <= '0;
		count     <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		errors = 0;
		items_sent = 0;
		reads_sent = 0;
		advances_sent = 0;
		reads_seen = 0;
		cfg_writes = 0;
		burst_left = 0;
		steady = 1'b0;
		recip_q24 = RECIP_ONE;
		for (int i = 0; i < N_PARAMS; i++) begin
			level_mem[i] = '0;
			slope_mem[i] = '0;
		end

		dir_tbl[0]  = '{CMD_READ,        6'd0,  32'h0000_0000, 16'd0,     1'b1, 32'h0000_0000};
		dir_tbl[1]  = '{CMD_READ,        6'd63, 32'hFFFF_FFFF, 16'hFFFF,  1'b1, 32'h0000_0000};
		dir_tbl[2]  = '{CMD_SET_CURRENT, 6'd0,  32'h7FFF_FFFF, 16'd0,     1'b0, 32'h0};
		dir_tbl[3]  = '{CMD_READ,        6'd0,  32'h0000_0000, 16'd0,     1'b1, 32'h7FFF_FFFF};
		dir_tbl[4]  = '{CMD_SET_CURRENT, 6'd63, 32'h8000_0000, 16'hFFFF,  1'b0, 32'h0};
		dir_tbl[5]  = '{CMD_READ,        6'd63, 32'h0000_0000, 16'd0,     1'b1, 32'h8000_0000};
		// full-scale target: slope saturates high
		dir_tbl[6]  = '{CMD_SET_TARGET,  6'd63, 32'h7FFF_FFFF, 16'd0,     1'b0, 32'h0};
		dir_tbl[7]  = '{CMD_READ,        6'd63, 32'h0000_0000, 16'hFFFF,  1'b1, 32'h7FFF_FFFF};
		dir_tbl[8]  = '{CMD_READ,        6'd63, 32'h0000_0000, 16'd1,     1'b1, 32'hFFFF_FFFF};
		// full-scale target downward: slope saturates low
		dir_tbl[9]  = '{CMD_SET_TARGET,  6'd0,  32'h8000_0000, 16'd0,     1'b0, 32'h0};
		dir_tbl[10] = '{CMD_READ,        6'd0,  32'h0000_0000, 16'd2,     1'b1, 32'h8000_0000};
		dir_tbl[11] = '{CMD_ADVANCE,     6'd0,  32'h0000_0000, 16'd0,     1'b0, 32'h0};
		dir_tbl[12] = '{CMD_READ,        6'd0,  32'h0000_0000, 16'd0,     1'b1, 32'h7FFF_FFFF};
		dir_tbl[13] = '{CMD_ADVANCE,     6'd0,  32'h0000_0000, 16'd1,     1'b0, 32'h0};
		dir_tbl[14] = '{CMD_READ,        6'd0,  32'h0000_0000, 16'd0,     1'b0, 32'h0};
		dir_tbl[15] = '{CMD_SET_CURRENT, 6'd5,  32'h0001_0000, 16'd0,     1'b0, 32'h0};
		dir_tbl[16] = '{CMD_SET_TARGET,  6'd5,  32'h000A_0000, 16'd0,     1'b0, 32'h0};
		dir_tbl[17] = '{CMD_READ,        6'd5,  32'h0000_0000, 16'd3,     1'b0, 32'h0};
		// long advance drives every live ramp into saturation
		dir_tbl[18] = '{CMD_ADVANCE,     6'd0,  32'h0000_0000, 16'hFFFF,  1'b0, 32'h0};
		dir_tbl[19] = '{CMD_READ,        6'd63, 32'h0000_0000, 16'd0,     1'b0, 32'h0};
		dir_tbl[20] = '{CMD_READ,        6'd5,  32'h0000_0000, 16'd0,     1'b0, 32'h0};
		dir_tbl[21] = '{CMD_READ,        6'd0,  32'h0000_0000, 16'hFFFF,  1'b0, 32'h0};
		dir_tbl[22] = '{CMD_SET_CURRENT, 6'd42, 32'h5555_AAAA, 16'h5555,  1'b0, 32'h0};
		dir_tbl[23] = '{CMD_SET_TARGET,  6'd42, 32'hAAAA_5555, 16'hAAAA,  1'b0, 32'h0};
		dir_tbl[24] = '{CMD_READ,        6'd42, 32'h0000_0000, 16'hAAAA,  1'b0, 32'h0};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		for (int k = 0; k < DIR_ROWS; k++)
			send_paced(dir_tbl[k]);

		// zero reciprocal, above one, half, smallest step, random, back to one
		set_recip('0);
		run_phase(63);
		set_recip(25'h1FF_FFFF);
		run_phase(63);
		set_recip(25'h080_0000);
		steady = 1'b1;
		run_phase(63);
		steady = 1'b0;
		set_recip(25'h000_0001);
		run_phase(30);
		settle();
		run_phase(33);
		set_recip(25'($urandom_range(0, 25'h1FF_FFFF)));
		run_phase(63);
		set_recip(RECIP_ONE);
		run_phase(63);

		settle();
		$display("covered %0d commands: %0d reads checked of %0d sent, %0d advances",
			items_sent, reads_seen, reads_sent, advances_sent);
		$display("over %0d reciprocal settings including zero, one and above one", cfg_writes);
		if (errors == 0 && lookahead_q.size() == 0) begin
			$display("multi_channel_parameter_ramp test passed");
		end else begin
			$display("multi_channel_parameter_ramp test failed");
		end
		$finish;
	end

endmodule

>>> files.f
src/mcpr_pkg.sv
src/multi_channel_parameter_ramp.sv
verif/tb_top.sv
